FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/gmtf_pkg.sv
package gmtf_pkg;

  localparam int VID_W  = 32;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ORDER = 2'd2;
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd3;

  localparam logic CMD_EDGE   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // request from the sequencer to the result stage
  typedef struct packed {
    logic              emit;
    logic              flush;
    logic [VID_W-1:0]  vertex;
    logic [STAT_W-1:0] status;
  } res_req_t;

endpackage

FILE: rtl/gmtf_ram.sv
module gmtf_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/gmtf_res.sv
module gmtf_res
  import gmtf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  res_req_t          req,
  output logic              res_ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [VID_W-1:0]  m_tdata,  // vertex_id
  output logic [STAT_W-1:0] m_tuser,  // status
  output logic              m_tlast   // last_of_run
);

  // one word is held back until we know whether it closes the run
  logic              hold_v;
  logic [VID_W-1:0]  hold_vertex;
  logic [STAT_W-1:0] hold_status;
  logic              out_free;

  assign out_free  = !m_tvalid || m_tready;
  assign res_ready = !hold_v || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (req.emit && res_ready) begin
        if (hold_v) begin
          m_tvalid <= 1'b1;
          m_tdata  <= hold_vertex;
          m_tuser  <= hold_status;
          m_tlast  <= 1'b0;
        end else if (m_tready) begin
          m_tvalid <= 1'b0;
        end
        hold_v      <= 1'b1;
        hold_vertex <= req.vertex;
        hold_status <= req.status;
      end else if (req.flush && res_ready && hold_v) begin
        m_tvalid <= 1'b1;
        m_tdata  <= hold_vertex;
        m_tuser  <= hold_status;
        m_tlast  <= 1'b1;
        hold_v   <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/greedy_mis_time_forward_top.sv
// Greedy maximal independent set over a stream of edges sorted by source.
// Pending marks live in a single-port-write, registered-read RAM; every group
// resolution is one pass over the live entries that pops the group, compacts
// the store in place and finds the next minimum. An edge of the current source
// goes straight to the push; a new source or a finish first resolves groups.
// Handing over a result waits while the output stalls. Results leave through
// a held word so tlast can close the run; ingress is taken only while the
// sequencer is idle.
`include "assert_macros.svh"

module greedy_mis_time_forward_top
  import gmtf_pkg::*;
#(
  parameter int STORE_DEPTH = 32,
  parameter int VERTEX_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [63:0]       s_tdata,  // source_vertex, target_vertex
  input  logic              s_tuser,  // command
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [VID_W-1:0]  m_tdata,  // vertex_id
  output logic [STAT_W-1:0] m_tuser,  // status
  output logic              m_tlast   // last_of_run
);

  localparam int VB = VERTEX_BITS;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_EMIT   = 6'b001000,
    S_PUSH   = 6'b010000,
    S_FLUSH  = 6'b100000
  } state_t;

  state_t state, ret;

  logic [CW-1:0] cnt, r, w;
  logic          rd_v;
  logic          drain;
  logic          match_en;
  logic [VB-1:0] match_v, min_v;
  logic          flag, member;
  logic [VB-1:0] s_reg, t_reg, cur;
  logic          seen, in_set;
  logic [VID_W-1:0]  ev;
  logic [STAT_W-1:0] est;

  logic [VB-1:0] s_in, t_in;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VB:0]   wr_data, rd_data;
  logic          res_ready;
  res_req_t      req;

  assign s_in     = VB'(s_tdata[31:0]);
  assign t_in     = VB'(s_tdata[63:32]);
  assign s_tready = (state == S_IDLE);
  assign rd_en    = (state == S_SCAN) && (r < cnt);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = w[AW-1:0];
    wr_data = rd_data;
    if (state == S_SCAN && rd_v && !(match_en && rd_data[VB-1:0] == match_v)) begin
      wr_en = 1'b1;
    end else if (state == S_PUSH && cnt < DEPTH_C) begin
      wr_en   = 1'b1;
      wr_addr = cnt[AW-1:0];
      wr_data = {in_set, t_reg};
    end
  end

  always_comb begin
    req.emit   = (state == S_EMIT);
    req.flush  = (state == S_FLUSH);
    req.vertex = ev;
    req.status = est;
  end

  gmtf_ram #(.WIDTH(VB + 1), .DEPTH(STORE_DEPTH)) u_marks (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (r[AW-1:0]),
    .rd_data (rd_data)
  );

  gmtf_res u_res (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_ready (res_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ret    <= S_IDLE;
      cnt    <= '0;
      r      <= '0;
      w      <= '0;
      rd_v   <= 1'b0;
      cur    <= '0;
      seen   <= 1'b0;
      in_set <= 1'b0;
      match_en <= 1'b0;
      drain  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            s_reg <= s_in;
            t_reg <= t_in;
            r     <= '0;
            w     <= '0;
            flag  <= 1'b0;
            min_v <= '1;
            match_en <= 1'b0;
            member   <= 1'b1;
            if (s_tuser == CMD_FINISH) begin
              drain <= 1'b1;
              state <= S_SCAN;
            end else if (seen && s_in < cur) begin
              ev    <= VID_W'(s_in);
              est   <= ST_ORDER;
              ret   <= S_FLUSH;
              state <= S_EMIT;
            end else if (t_in <= s_in) begin
              ev    <= VID_W'(t_in);
              est   <= ST_ORDER;
              ret   <= S_FLUSH;
              state <= S_EMIT;
            end else if (!seen || s_in != cur) begin
              drain <= 1'b0;
              state <= S_SCAN;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_SCAN: begin
          rd_v <= rd_en;
          if (rd_en) begin
            r <= r + 1'b1;
          end
          if (rd_v) begin
            if (match_en && rd_data[VB-1:0] == match_v) begin
              flag <= flag | rd_data[VB];
            end else begin
              w <= w + 1'b1;
              if (rd_data[VB-1:0] < min_v) begin
                min_v <= rd_data[VB-1:0];
              end
            end
          end
          if (!rd_en && !rd_v) begin
            cnt   <= w;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          r <= '0;
          w <= '0;
          if (match_en) begin
            // a group was just popped
            match_en <= 1'b0;
            if (!drain && match_v == s_reg) begin
              member <= !flag;
            end else if (!flag) begin
              ev    <= VID_W'(match_v);
              est   <= ST_ADDED;
              ret   <= S_DECIDE;
              state <= S_EMIT;
            end
          end else if (cnt != '0 && (drain || min_v <= s_reg)) begin
            match_en <= 1'b1;
            match_v  <= min_v;
            min_v    <= '1;
            flag     <= 1'b0;
            state    <= S_SCAN;
          end else if (drain) begin
            ev     <= '0;
            est    <= ST_DONE;
            ret    <= S_FLUSH;
            state  <= S_EMIT;
            cur    <= '0;
            seen   <= 1'b0;
            in_set <= 1'b0;
          end else begin
            cur    <= s_reg;
            seen   <= 1'b1;
            in_set <= member;
            if (member) begin
              ev    <= VID_W'(s_reg);
              est   <= ST_ADDED;
              ret   <= S_PUSH;
              state <= S_EMIT;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= ret;
          end
        end
        S_PUSH: begin
          if (cnt >= DEPTH_C) begin
            ev    <= VID_W'(t_reg);
            est   <= ST_FULL;
            ret   <= S_FLUSH;
            state <= S_EMIT;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_cnt_bound, cnt <= DEPTH_C, "pending count above store depth")
  `ASSERT_CLK(a_compact_behind, (state == S_SCAN) |-> (w <= r), "compaction overtook read")
  `ASSERT_CLK(a_push_grows, (state == S_PUSH && cnt < DEPTH_C) |=> (cnt == $past(cnt) + 1'b1),
    "push did not grow the store")
  `ASSERT_NEVER(a_no_rw_clash, wr_en && rd_en && wr_addr == r[AW-1:0], "write hit read address")

endmodule
